// ----- design/lsme_pkg.sv -----
// ----------------------------------------------------------------------------
// Line segment mesh expander package
// Shared types, register codes and corner tables of the line segment mesh
// expander.
// ----------------------------------------------------------------------------
package lsme_pkg;

    // Geometry modes
    localparam logic MODE_TET   = 1'b0;
    localparam logic MODE_PRISM = 1'b1;

    // Result kinds
    localparam logic KIND_INDEX  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    // Sequence lengths per line
    localparam int STEP_W       = 5;
    localparam int TET_IDX_N    = 12;
    localparam int PRISM_IDX_N  = 24;
    localparam int TET_LAST     = 15;
    localparam int PRISM_LAST   = 29;

    // Register reset values
    localparam logic [47:0] OFFSET_A_RST = 48'h0000_4000_0000;
    localparam logic [47:0] OFFSET_B_RST = 48'h0000_E000_C893;
    localparam logic [47:0] OFFSET_C_RST = 48'h0000_E000_376D;

    // Register map, indexed by the double-word address
    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_OFFSET_A = 2'd1,
        REG_OFFSET_B = 2'd2,
        REG_OFFSET_C = 2'd3
    } cfg_addr_t;

    // Offset vector selection codes
    localparam logic [1:0] VEC_A = 2'd0;
    localparam logic [1:0] VEC_B = 2'd1;
    localparam logic [1:0] VEC_C = 2'd2;

    // Which endpoint and offset one vertex uses
    typedef struct packed {
        logic       use_end;
        logic       use_off;
        logic [1:0] vec;
    } vsel_t;

    // One line held for expansion
    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_z;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [31:0] end_z;
        logic [15:0] size;
        logic [31:0] head_color;
        logic [31:0] tail_color;
        logic [31:0] u_coord;
    } line_t;

    // Per-cycle control from the sequencer to the result stage
    typedef struct packed {
        logic        issue;
        logic        kind;
        logic [15:0] vertex_index;
        vsel_t       sel;
        logic        last;
    } ctrl_t;

    // Corner order of the four tetrahedron triangles
    function automatic logic [2:0] tet_corner(input logic [STEP_W-1:0] step);
        logic [2:0] c;
        case (step)
            5'd0:    c = 3'd0;
            5'd1:    c = 3'd2;
            5'd2:    c = 3'd1;
            5'd3:    c = 3'd0;
            5'd4:    c = 3'd3;
            5'd5:    c = 3'd2;
            5'd6:    c = 3'd0;
            5'd7:    c = 3'd1;
            5'd8:    c = 3'd3;
            5'd9:    c = 3'd1;
            5'd10:   c = 3'd2;
            5'd11:   c = 3'd3;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // Corner order of the eight prism triangles
    function automatic logic [2:0] prism_corner(input logic [STEP_W-1:0] step);
        logic [2:0] c;
        case (step)
            5'd0:    c = 3'd0;
            5'd1:    c = 3'd1;
            5'd2:    c = 3'd2;
            5'd3:    c = 3'd0;
            5'd4:    c = 3'd3;
            5'd5:    c = 3'd1;
            5'd6:    c = 3'd1;
            5'd7:    c = 3'd3;
            5'd8:    c = 3'd4;
            5'd9:    c = 3'd1;
            5'd10:   c = 3'd4;
            5'd11:   c = 3'd5;
            5'd12:   c = 3'd1;
            5'd13:   c = 3'd5;
            5'd14:   c = 3'd2;
            5'd15:   c = 3'd0;
            5'd16:   c = 3'd2;
            5'd17:   c = 3'd5;
            5'd18:   c = 3'd0;
            5'd19:   c = 3'd5;
            5'd20:   c = 3'd3;
            5'd21:   c = 3'd3;
            5'd22:   c = 3'd5;
            5'd23:   c = 3'd4;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // Vertex source: tetrahedron gives the bare end point, then start plus
    // A, B, C; prism gives start plus A, B, C, then end plus A, B, C.
    function automatic vsel_t vertex_select(input logic mode, input logic [2:0] vidx);
        vsel_t s;
        s = '0;
        if (mode == MODE_TET) begin
            case (vidx)
                3'd0:    s = '{use_end: 1'b1, use_off: 1'b0, vec: VEC_A};
                3'd1:    s = '{use_end: 1'b0, use_off: 1'b1, vec: VEC_A};
                3'd2:    s = '{use_end: 1'b0, use_off: 1'b1, vec: VEC_B};
                default: s = '{use_end: 1'b0, use_off: 1'b1, vec: VEC_C};
            endcase
        end
        else begin
            case (vidx)
                3'd0:    s = '{use_end: 1'b0, use_off: 1'b1, vec: VEC_A};
                3'd1:    s = '{use_end: 1'b0, use_off: 1'b1, vec: VEC_B};
                3'd2:    s = '{use_end: 1'b0, use_off: 1'b1, vec: VEC_C};
                3'd3:    s = '{use_end: 1'b1, use_off: 1'b1, vec: VEC_A};
                3'd4:    s = '{use_end: 1'b1, use_off: 1'b1, vec: VEC_B};
                default: s = '{use_end: 1'b1, use_off: 1'b1, vec: VEC_C};
            endcase
        end
        return s;
    endfunction

endpackage

// ----- design/line_segment_mesh_expander_top.sv -----
// ----------------------------------------------------------------------------
// Line segment mesh expander
// Expands each line segment into triangle indices and offset vertices.
// ----------------------------------------------------------------------------
// Each accepted line produces 16 results in tetrahedron mode (12 indices,
// 4 vertices) or 30 in prism mode (24 indices, 6 vertices), one result per
// output transfer, and one result per cycle while the output is not stalled.
// The first result passes through the line register and then the output
// register, and the next line is accepted in the cycle that the last result
// of the current line is issued, so lines follow without gaps.
// Registers sit at byte addresses 0 (mode), 8, 16 and 24 (offsets A, B, C)
// and should be written only while the block is idle.
module line_segment_mesh_expander_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] start_z,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [31:0] end_z,
    input  logic [15:0] size,
    input  logic [31:0] head_color,
    input  logic [31:0] tail_color,
    input  logic [31:0] u_coord,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [15:0] vertex_index,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [31:0] color,
    output logic [31:0] tex_u,
    output logic        v_end,
    output logic        last
);
    import lsme_pkg::*;

    logic        mode;
    logic [47:0] offset_a;
    logic [47:0] offset_b;
    logic [47:0] offset_c;
    logic        take;
    line_t       line;
    ctrl_t       ctrl;

    // Configuration registers.
    lsme_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .mode     (mode),
        .offset_a (offset_a),
        .offset_b (offset_b),
        .offset_c (offset_c)
    );

    // Line register and step sequencer.
    lsme_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .size       (size),
        .head_color (head_color),
        .tail_color (tail_color),
        .u_coord    (u_coord),
        .mode       (mode),
        .take       (take),
        .line       (line),
        .ctrl       (ctrl)
    );

    // Result computation and output register.
    lsme_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .line         (line),
        .ctrl         (ctrl),
        .offset_a     (offset_a),
        .offset_b     (offset_b),
        .offset_c     (offset_c),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .color        (color),
        .tex_u        (tex_u),
        .v_end        (v_end),
        .last         (last)
    );

endmodule

// ----- design/lsme_cfg.sv -----
// ----------------------------------------------------------------------------
// Line segment mesh expander configuration registers
// APB-style register file holding the mode and the three offset vectors.
// ----------------------------------------------------------------------------
module lsme_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic        mode,
    output logic [47:0] offset_a,
    output logic [47:0] offset_b,
    output logic [47:0] offset_c
);
    import lsme_pkg::*;

    logic        mode_reg;
    logic [47:0] offset_a_reg;
    logic [47:0] offset_b_reg;
    logic [47:0] offset_c_reg;
    logic        wr_en;
    cfg_addr_t   addr;

    assign pready = 1'b1;
    assign addr   = cfg_addr_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite;

    // Register writes complete in the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TET;
            offset_a_reg <= OFFSET_A_RST;
            offset_b_reg <= OFFSET_B_RST;
            offset_c_reg <= OFFSET_C_RST;
        end
        else if (wr_en)
        begin
            unique case (addr)
                REG_MODE:     mode_reg     <= pwdata[0];
                REG_OFFSET_A: offset_a_reg <= pwdata[47:0];
                REG_OFFSET_B: offset_b_reg <= pwdata[47:0];
                REG_OFFSET_C: offset_c_reg <= pwdata[47:0];
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (addr)
            REG_MODE:     prdata = {63'd0, mode_reg};
            REG_OFFSET_A: prdata = {16'd0, offset_a_reg};
            REG_OFFSET_B: prdata = {16'd0, offset_b_reg};
            REG_OFFSET_C: prdata = {16'd0, offset_c_reg};
            default:      prdata = '0;
        endcase
    end

    assign mode     = mode_reg;
    assign offset_a = offset_a_reg;
    assign offset_b = offset_b_reg;
    assign offset_c = offset_c_reg;

endmodule

// ----- design/lsme_seq.sv -----
// ----------------------------------------------------------------------------
// Line segment mesh expander sequencer
// Input register for one line, the running line count and the step counter
// that walks through the index and vertex results of the held line.
// ----------------------------------------------------------------------------
module lsme_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                restart,
    input  logic [31:0]         start_x,
    input  logic [31:0]         start_y,
    input  logic [31:0]         start_z,
    input  logic [31:0]         end_x,
    input  logic [31:0]         end_y,
    input  logic [31:0]         end_z,
    input  logic [15:0]         size,
    input  logic [31:0]         head_color,
    input  logic [31:0]         tail_color,
    input  logic [31:0]         u_coord,
    input  logic                mode,
    input  logic                take,
    output lsme_pkg::line_t     line,
    output lsme_pkg::ctrl_t     ctrl
);
    import lsme_pkg::*;

    line_t             line_reg;
    logic              line_valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic [15:0]       line_count_reg;
    logic [15:0]       base_reg;

    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] n_idx;
    logic [STEP_W-1:0] vstep;
    logic              issue;
    logic              last_issue;
    logic              accept;
    logic [15:0]       cnt;
    logic [15:0]       base_next;
    logic [2:0]        corner;

    // Handshake: a new line enters as the held one issues its last result.
    assign last_step  = (mode == MODE_PRISM) ? STEP_W'(PRISM_LAST) : STEP_W'(TET_LAST);
    assign n_idx      = (mode == MODE_PRISM) ? STEP_W'(PRISM_IDX_N) : STEP_W'(TET_IDX_N);
    assign issue      = line_valid_reg && take;
    assign last_issue = issue && (step_reg == last_step);
    assign in_stall   = line_valid_reg && !last_issue;
    assign accept     = in_valid && !in_stall;

    // Index base of the line: vertex count per line times the line count.
    assign cnt       = restart ? 16'd0 : line_count_reg;
    assign base_next = (mode == MODE_PRISM) ? ({cnt[13:0], 2'b00} + {cnt[14:0], 1'b0})
                                            : {cnt[13:0], 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= 1'b0;
            step_reg       <= '0;
            line_count_reg <= '0;
        end
        else if (accept)
        begin
            line_valid_reg <= 1'b1;
            step_reg       <= '0;
            line_count_reg <= cnt + 16'd1;
        end
        else if (last_issue)
        begin
            line_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // Line payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg.start_x    <= start_x;
            line_reg.start_y    <= start_y;
            line_reg.start_z    <= start_z;
            line_reg.end_x      <= end_x;
            line_reg.end_y      <= end_y;
            line_reg.end_z      <= end_z;
            line_reg.size       <= size;
            line_reg.head_color <= head_color;
            line_reg.tail_color <= tail_color;
            line_reg.u_coord    <= u_coord;
            base_reg            <= base_next;
        end
    end

    // Decode of the current step.
    assign corner = (mode == MODE_PRISM) ? prism_corner(step_reg) : tet_corner(step_reg);
    assign vstep  = step_reg - n_idx;

    always_comb
    begin
        ctrl.issue        = issue;
        ctrl.kind         = (step_reg >= n_idx) ? KIND_VERTEX : KIND_INDEX;
        ctrl.vertex_index = base_reg + {13'd0, corner};
        ctrl.sel          = vertex_select(mode, vstep[2:0]);
        ctrl.last         = (step_reg == last_step);
    end

    assign line = line_reg;

endmodule

// ----- design/lsme_out.sv -----
// ----------------------------------------------------------------------------
// Line segment mesh expander result stage
// Computes one index or vertex result from the held line and registers it
// for the output channel.
// ----------------------------------------------------------------------------
module lsme_out (
    input  logic               clk,
    input  logic               rst_n,
    input  lsme_pkg::line_t    line,
    input  lsme_pkg::ctrl_t    ctrl,
    input  logic [47:0]        offset_a,
    input  logic [47:0]        offset_b,
    input  logic [47:0]        offset_c,
    output logic               take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [15:0]        vertex_index,
    output logic [31:0]        pos_x,
    output logic [31:0]        pos_y,
    output logic [31:0]        pos_z,
    output logic [31:0]        color,
    output logic [31:0]        tex_u,
    output logic               v_end,
    output logic               last
);
    import lsme_pkg::*;

    // Endpoint plus size times one Q1.14 component, rounded half up to
    // Q16.16 and saturated to the signed 32-bit range.
    function automatic logic [31:0] add_offset(input logic [31:0] pt,
                                               input logic [15:0] sz,
                                               input logic [15:0] comp);
        logic signed [32:0] prod;
        logic signed [33:0] rnd;
        logic signed [33:0] sum;
        logic [31:0]        res;
        prod = $signed({1'b0, sz}) * $signed(comp);
        rnd  = $signed({prod[32], prod}) + 34'sd32;
        sum  = $signed({{2{pt[31]}}, pt}) + (rnd >>> 6);
        if (!sum[33] && (sum[32] || sum[31]))
            res = 32'h7FFF_FFFF;
        else if (sum[33] && !(sum[32] && sum[31]))
            res = 32'h8000_0000;
        else
            res = sum[31:0];
        return res;
    endfunction

    logic        out_valid_reg;
    logic        kind_reg;
    logic [15:0] vertex_index_reg;
    logic [31:0] pos_x_reg;
    logic [31:0] pos_y_reg;
    logic [31:0] pos_z_reg;
    logic [31:0] color_reg;
    logic [31:0] tex_u_reg;
    logic        v_end_reg;
    logic        last_reg;

    logic [47:0] vec;
    logic [31:0] pt_x;
    logic [31:0] pt_y;
    logic [31:0] pt_z;
    logic        is_vtx;
    logic [15:0] vertex_index_next;
    logic [31:0] pos_x_next;
    logic [31:0] pos_y_next;
    logic [31:0] pos_z_next;
    logic [31:0] color_next;
    logic [31:0] tex_u_next;
    logic        v_end_next;

    // The output register accepts a new result when empty or when drained.
    assign take = !out_valid_reg || !out_stall;

    // Offset vector and endpoint selection; a bare endpoint adds zero.
    always_comb
    begin
        case (ctrl.sel.vec)
            VEC_A:   vec = offset_a;
            VEC_B:   vec = offset_b;
            VEC_C:   vec = offset_c;
            default: vec = '0;
        endcase
        if (!ctrl.sel.use_off)
            vec = '0;
    end

    assign pt_x   = ctrl.sel.use_end ? line.end_x : line.start_x;
    assign pt_y   = ctrl.sel.use_end ? line.end_y : line.start_y;
    assign pt_z   = ctrl.sel.use_end ? line.end_z : line.start_z;
    assign is_vtx = (ctrl.kind == KIND_VERTEX);

    // Three position lanes and field selection by result kind.
    assign pos_x_next        = is_vtx ? add_offset(pt_x, line.size, vec[15:0])  : '0;
    assign pos_y_next        = is_vtx ? add_offset(pt_y, line.size, vec[31:16]) : '0;
    assign pos_z_next        = is_vtx ? add_offset(pt_z, line.size, vec[47:32]) : '0;
    assign color_next        = !is_vtx ? '0
                             : (ctrl.sel.use_end ? line.tail_color : line.head_color);
    assign tex_u_next        = is_vtx ? line.u_coord : '0;
    assign v_end_next        = is_vtx && ctrl.sel.use_end;
    assign vertex_index_next = is_vtx ? '0 : ctrl.vertex_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.issue)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            kind_reg         <= ctrl.kind;
            vertex_index_reg <= vertex_index_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            pos_z_reg        <= pos_z_next;
            color_reg        <= color_next;
            tex_u_reg        <= tex_u_next;
            v_end_reg        <= v_end_next;
            last_reg         <= ctrl.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign vertex_index = vertex_index_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign color        = color_reg;
    assign tex_u        = tex_u_reg;
    assign v_end        = v_end_reg;
    assign last         = last_reg;

endmodule
